@@ design/kltp_pkg.sv @@
// ----------------------------------------------------------------------------
// kltp_pkg
// Shared types and constants for the key tap / long press tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package kltp_pkg;

   localparam int NUM_KEYS   = 256;
   localparam int COUNT_BITS = 16;

   localparam int KEY_BITS   = 8;
   localparam int THR_BITS   = 16;
   localparam int SHOW_BITS  = 16;
   localparam int ADDR_BITS  = (NUM_KEYS > 2) ? $clog2(NUM_KEYS) : 1;
   // index compare width: covers both the key field and the table depth
   localparam int IDX_BITS   = (ADDR_BITS > KEY_BITS) ? ADDR_BITS : KEY_BITS;
   localparam int CMP_BITS   = (COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [SHOW_BITS-1:0]  SHOW_MAX  = {SHOW_BITS{1'b1}};
   localparam logic [THR_BITS-1:0]   THR_RESET = THR_BITS'(30);

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LONG_PRESS_FRAMES = '0;

   typedef enum logic [1:0] {
      CLASS_NONE = 2'd0,
      CLASS_TAP  = 2'd1,
      CLASS_LONG = 2'd2
   } press_class_type;

   // one key table entry; previous level and captured count are not kept,
   // both are rebuilt from the stored level and count on the next sample
   typedef struct packed {
      logic                  curr;
      logic [COUNT_BITS-1:0] hold;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] addr;
      entry_type            data;
   } fwd_type;

   typedef struct packed {
      logic                 held;
      logic                 just_pressed;
      logic                 just_released;
      logic [SHOW_BITS-1:0] hold_count;
      press_class_type      press_class;
   } result_type;

endpackage

`default_nettype wire

@@ design/key_tap_long_press_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// key_tap_long_press_tracker_unit
// Per-key held / edge / hold count tracking with tap and long press classes.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req_    | in  | frame sample: key_index, key_down, has_focus
//  rsp_    | out | key state: result_key, held, edges, hold_count, press_class
//  csr_    | in  | APB, register 0 = long_press_frames
//
//  One item per cycle while rsp_ accepts. An item reads the key table as
//  it is accepted, updates and writes back from the update stage while
//  its result is registered; a write to the key just read is forwarded.
//  After reset a clearing pass zeroes the table with req_tready low.
//  A stalled rsp_ holds one item and the update stage holds one more
//  before req_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module key_tap_long_press_tracker_unit
   import kltp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // [7:0] key_index, [8] key_down, [9] has_focus, [15:10] zero
   input  wire logic [15:0]              req_tdata,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // [7:0] result_key, [8] held, [9] just_pressed, [10] just_released,
   // [26:11] hold_count, [28:27] press_class, [31:29] zero
   output logic      [31:0]              rsp_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   logic [THR_BITS-1:0] threshold;

   kltp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .threshold   (threshold)
   );

   // ---------------- clearing pass ----------------
   logic                 clr_active_ff, clr_active_in;
   logic [ADDR_BITS-1:0] clr_addr_ff,   clr_addr_in;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
         if (clr_addr_ff == ADDR_BITS'(NUM_KEYS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   // ---------------- accept ----------------
   logic                 advance;
   logic                 req_fire;
   logic [KEY_BITS-1:0]  in_key;
   logic [IDX_BITS-1:0]  in_key_ext;
   logic [ADDR_BITS-1:0] in_addr;

   logic                 s1_valid_ff, s1_valid_in;
   logic [KEY_BITS-1:0]  s1_key_ff;
   logic [ADDR_BITS-1:0] s1_addr_ff;
   logic                 s1_in_range_ff;
   logic                 s1_level_ff;
   logic                 s1_move;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = !clr_active_ff && (!s1_valid_ff || advance);
   assign req_fire   = req_tvalid && req_tready;

   assign in_key     = req_tdata[KEY_BITS-1:0];
   assign in_key_ext = IDX_BITS'(in_key);
   assign in_addr    = in_key_ext[ADDR_BITS-1:0];

   // ---------------- update stage ----------------
   assign s1_move     = s1_valid_ff && advance;
   assign s1_valid_in = req_fire || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_key_ff      <= in_key;
         s1_addr_ff     <= in_addr;
         s1_in_range_ff <= {1'b0, in_key_ext} < (IDX_BITS + 1)'(NUM_KEYS);
         s1_level_ff    <= req_tdata[8] && req_tdata[9];
      end
   end

   entry_type  rd_data;
   entry_type  new_entry;
   result_type result;
   fwd_type    fwd_ff, fwd_in;
   logic       upd_write;

   assign upd_write = s1_move && s1_in_range_ff;

   kltp_update u_update (
      .rd_data   (rd_data),
      .fwd       (fwd_ff),
      .addr      (s1_addr_ff),
      .in_range  (s1_in_range_ff),
      .level     (s1_level_ff),
      .threshold (threshold),
      .new_entry (new_entry),
      .result    (result)
   );

   logic                 ram_wr_en;
   logic [ADDR_BITS-1:0] ram_wr_addr;
   entry_type            ram_wr_data;

   assign ram_wr_en   = clr_active_ff || upd_write;
   assign ram_wr_addr = clr_active_ff ? clr_addr_ff : s1_addr_ff;
   assign ram_wr_data = clr_active_ff ? '0 : new_entry;

   kltp_key_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (in_addr),
      .rd_data (rd_data)
   );

   // last table write; covers a read issued on the same edge
   always_comb begin
      fwd_in = fwd_ff;
      if (upd_write) begin
         fwd_in.valid = 1'b1;
         fwd_in.addr  = s1_addr_ff;
         fwd_in.data  = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff.valid <= 1'b0;
      end else begin
         fwd_ff.valid <= fwd_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      fwd_ff.addr <= fwd_in.addr;
      fwd_ff.data <= fwd_in.data;
   end

   // ---------------- output register ----------------
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff;

   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= {3'b000, result.press_class, result.hold_count,
                         result.just_released, result.just_pressed, result.held,
                         s1_key_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ design/kltp_key_ram.sv @@
// ----------------------------------------------------------------------------
// kltp_key_ram
// Key table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kltp_key_ram
   import kltp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire entry_type            wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output entry_type                 rd_data
);

   entry_type mem [NUM_KEYS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/kltp_update.sv @@
// ----------------------------------------------------------------------------
// kltp_update
// Entry update and classification for one sample, with write forwarding.
// ----------------------------------------------------------------------------
`default_nettype none

module kltp_update
   import kltp_pkg::*;
(
   input  wire entry_type             rd_data,
   input  wire fwd_type               fwd,
   input  wire logic [ADDR_BITS-1:0]  addr,
   input  wire logic                  in_range,
   input  wire logic                  level,
   input  wire logic [THR_BITS-1:0]   threshold,
   output entry_type                  new_entry,
   output result_type                 result
);

   entry_type             old_entry;
   logic                  prev;
   logic [COUNT_BITS-1:0] hold_next;
   logic [CMP_BITS-1:0]   thr_ext;
   logic [CMP_BITS-1:0]   old_ext;
   logic [CMP_BITS-1:0]   new_ext;

   // the read raced the previous item's write to the same key
   assign old_entry = (fwd.valid && fwd.addr == addr) ? fwd.data : rd_data;
   assign prev      = old_entry.curr;

   always_comb begin
      if (!level) begin
         hold_next = '0;
      end else if (!prev) begin
         hold_next = COUNT_BITS'(1);
      end else if (old_entry.hold != COUNT_MAX) begin
         hold_next = old_entry.hold + COUNT_BITS'(1);
      end else begin
         hold_next = old_entry.hold;
      end
   end

   assign new_entry.curr = level;
   assign new_entry.hold = hold_next;

   assign thr_ext = CMP_BITS'(threshold);
   assign old_ext = CMP_BITS'(old_entry.hold);
   assign new_ext = CMP_BITS'(hold_next);

   always_comb begin
      result = '0;
      if (in_range) begin
         result.held          = level;
         result.just_pressed  = !prev && level;
         result.just_released = prev && !level;
         result.hold_count    = (new_ext > CMP_BITS'(SHOW_MAX)) ? SHOW_MAX
                                                              : new_ext[SHOW_BITS-1:0];
         // on release the count held so far is the captured count
         if (prev && !level) begin
            result.press_class = (old_ext < thr_ext) ? CLASS_TAP : CLASS_LONG;
         end else if (level && new_ext >= thr_ext) begin
            result.press_class = CLASS_LONG;
         end else begin
            result.press_class = CLASS_NONE;
         end
      end
   end

endmodule

`default_nettype wire

@@ design/kltp_csr.sv @@
// ----------------------------------------------------------------------------
// kltp_csr
// APB register block holding the long press threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module kltp_csr
   import kltp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready,
   output logic      [THR_BITS-1:0]      threshold
);

   logic [THR_BITS-1:0] thr_ff;
   logic [THR_BITS-1:0] thr_in;

   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_LONG_PRESS_FRAMES) begin
         thr_in = csr_pwdata[THR_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_LONG_PRESS_FRAMES) begin
         csr_prdata = CSR_DATA_BITS'(thr_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign threshold  = thr_ff;

endmodule

`default_nettype wire

@@ sim/tb_key_tap_long_press_tracker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_tap_long_press_tracker_unit
// Self-checking bench for the key tap / long press tracker. Frame samples go
// in on req_, every report coming out of rsp_ is compared against a per-key
// history model kept in the bench. Covers taps, long presses, focus loss,
// zero and full-scale thresholds and back-pressure.
// ----------------------------------------------------------------------------

module tb_key_tap_long_press_tracker_unit;
   import kltp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int POOL = 6;
   localparam int MAX_ERRORS_SHOWN = 40;

   typedef struct {
      logic [KEY_BITS-1:0]  key;
      logic                 held;
      logic                 just_pressed;
      logic                 just_released;
      logic [SHOW_BITS-1:0] hold_count;
      press_class_type      press_class;
   } key_report_type;

   // per-key history model and the queue of reports it expects
   class key_history_board;
      logic [THR_BITS-1:0]   threshold;
      logic                  level_prev [NUM_KEYS];
      logic                  level_curr [NUM_KEYS];
      logic [COUNT_BITS-1:0] hold_frames [NUM_KEYS];
      logic [COUNT_BITS-1:0] captured_frames [NUM_KEYS];
      key_report_type        expected_reports [$];
      int                    mismatches;
      int                    samples_noted;
      int                    reports_checked;

      function new();
         threshold = THR_RESET;
         mismatches = 0;
         samples_noted = 0;
         reports_checked = 0;
         foreach (level_curr[i]) begin
            level_prev[i] = 1'b0;
            level_curr[i] = 1'b0;
            hold_frames[i] = '0;
            captured_frames[i] = '0;
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void note_sample(logic [KEY_BITS-1:0] k, logic down, logic focus);
         key_report_type rep;
         logic           was_down;
         logic           now_down;
         was_down = level_curr[k];
         now_down = down & focus;
         level_prev[k] = was_down;
         level_curr[k] = now_down;
         if (now_down) begin
            if (!was_down)
               hold_frames[k] = COUNT_BITS'(1);
            else if (hold_frames[k] != COUNT_MAX)
               hold_frames[k] = hold_frames[k] + COUNT_BITS'(1);
         end else begin
            if (was_down)
               captured_frames[k] = hold_frames[k];
            hold_frames[k] = '0;
         end
         rep.key = k;
         rep.held = now_down;
         rep.just_pressed = !was_down && now_down;
         rep.just_released = was_down && !now_down;
         rep.hold_count = SHOW_BITS'(hold_frames[k]);
         if (was_down && !now_down)
            rep.press_class = (captured_frames[k] < threshold) ? CLASS_TAP : CLASS_LONG;
         else if (now_down && hold_frames[k] >= threshold)
            rep.press_class = CLASS_LONG;
         else
            rep.press_class = CLASS_NONE;
         expected_reports.push_back(rep);
         samples_noted++;
      endfunction

      function void compare_field(string name, int unsigned expv, int unsigned actv);
         if (expv !== actv) begin
            if (mismatches < MAX_ERRORS_SHOWN)
               $error("report %0d: %s expected %0d got %0d", reports_checked, name,
                      expv, actv);
            mismatches++;
         end
      endfunction

      function void check_report(logic [31:0] d);
         key_report_type rep;
         if (expected_reports.size() == 0) begin
            $error("report with no sample outstanding: 0x%08h", d);
            mismatches++;
            return;
         end
         rep = expected_reports.pop_front();
         compare_field("result_key", rep.key, d[7:0]);
         compare_field("held", rep.held, d[8]);
         compare_field("just_pressed", rep.just_pressed, d[9]);
         compare_field("just_released", rep.just_released, d[10]);
         compare_field("hold_count", rep.hold_count, d[26:11]);
         compare_field("press_class", 2'(rep.press_class), d[28:27]);
         reports_checked++;
      endfunction
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic [15:0]              req_tdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [31:0]              rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   key_history_board board = new();
   bit               no_gaps = 1'b0;
   bit               rsp_hold_off = 1'b0;
   int               hold_offs = 0;
   int               idle_cycles = 0;

   key_tap_long_press_tracker_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ends the run if neither channel moves an item for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
         $display("tb_key_tap_long_press_tracker_unit: FAIL");
         $finish;
      end
   end

   // report sink: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (rsp_hold_off) begin
            gap = HOLD_OFF_CYCLES;
            rsp_hold_off = 1'b0;
            hold_offs++;
         end else begin
            gap = no_gaps ? 0 : $urandom_range(0, 7);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_report(rsp_tdata);
      end
   end

   // valid is left high after a handshake; it only drops on a gap or a drain
   task automatic send_sample(logic [KEY_BITS-1:0] k, logic down, logic focus);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {6'b0, focus, down, k};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_sample(k, down, focus);
   endtask

   task automatic drain_reports();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic csr_access(logic wr, logic [CSR_DATA_BITS-1:0] wdata,
                             output logic [CSR_DATA_BITS-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= CSR_LONG_PRESS_FRAMES;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_threshold_readback();
      logic [CSR_DATA_BITS-1:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd[THR_BITS-1:0] !== board.threshold) begin
         $error("long_press_frames readback expected %0d got %0d", board.threshold,
                rd[THR_BITS-1:0]);
         board.mismatches++;
      end
   endtask

   task automatic set_threshold(logic [THR_BITS-1:0] thr);
      logic [CSR_DATA_BITS-1:0] rd;
      csr_access(1'b1, CSR_DATA_BITS'(thr), rd);
      board.threshold = thr;
      check_threshold_readback();
   endtask

   // mostly press/hold/release runs on a few keys, with lengths around the
   // threshold; the rest is noise on any key
   task automatic run_random_phase(int count, bit hold_off);
      logic [KEY_BITS-1:0] pool_key [POOL];
      bit                  pool_down [POOL];
      int                  pool_left [POOL];
      int                  slot;
      int                  thr;
      int                  len;
      logic [KEY_BITS-1:0] k;
      logic                d;
      logic                f;
      thr = int'(board.threshold);
      for (int i = 0; i < POOL; i++) begin
         pool_key[i] = KEY_BITS'($urandom_range(0, 255));
         pool_down[i] = 1'b0;
         pool_left[i] = 0;
      end
      for (int n = 0; n < count; n++) begin
         if (hold_off && n == count / 4)
            rsp_hold_off = 1'b1;
         slot = $urandom_range(0, POOL - 1);
         if ($urandom_range(0, 99) < 15) begin
            k = KEY_BITS'($urandom_range(0, 255));
            d = 1'($urandom_range(0, 1));
            f = 1'($urandom_range(0, 1));
         end else begin
            if (pool_left[slot] == 0) begin
               pool_down[slot] = !pool_down[slot];
               if (pool_down[slot]) begin
                  case ($urandom_range(0, 3))
                     0: len = thr - 1;
                     1: len = thr;
                     2: len = thr + 1;
                     default: len = $urandom_range(1, 2 * thr + 2);
                  endcase
                  pool_left[slot] = (len < 1) ? 1 : len;
               end else begin
                  pool_left[slot] = $urandom_range(1, 4);
               end
            end
            pool_left[slot]--;
            k = pool_key[slot];
            if (pool_down[slot]) begin
               d = 1'b1;
               f = 1'b1;
            end else begin
               // release by level, by focus loss, or both
               case ($urandom_range(0, 3))
                  0: begin d = 1'b0; f = 1'b0; end
                  1: begin d = 1'b1; f = 1'b0; end
                  default: begin d = 1'b0; f = 1'b1; end
               endcase
            end
         end
         send_sample(k, d, f);
      end
      drain_reports();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_threshold_readback();

      // directed: short taps, long presses, focus loss, both key extremes
      set_threshold(THR_BITS'(3));
      send_sample(8'h00, 1'b1, 1'b1);
      send_sample(8'h00, 1'b1, 1'b1);
      send_sample(8'h00, 1'b0, 1'b1);
      send_sample(8'h00, 1'b0, 1'b1);
      send_sample(8'hFF, 1'b1, 1'b0);
      send_sample(8'hFF, 1'b1, 1'b1);
      send_sample(8'hFF, 1'b1, 1'b1);
      send_sample(8'hFF, 1'b1, 1'b1);
      send_sample(8'hFF, 1'b1, 1'b0);
      send_sample(8'h80, 1'b1, 1'b1);
      send_sample(8'h80, 1'b0, 1'b0);
      drain_reports();

      // zero threshold: every held frame and every release is long
      set_threshold(THR_BITS'(0));
      send_sample(8'h01, 1'b0, 1'b1);
      send_sample(8'h01, 1'b1, 1'b1);
      send_sample(8'h01, 1'b1, 1'b1);
      send_sample(8'h01, 1'b0, 1'b1);
      send_sample(8'h7F, 1'b1, 1'b1);
      send_sample(8'h7F, 1'b0, 1'b1);
      drain_reports();

      // full-scale threshold, a held key stays below it and releases as a tap
      set_threshold('1);
      no_gaps = 1'b1;
      for (int i = 0; i < 40; i++)
         send_sample(8'hA5, 1'b1, 1'b1);
      send_sample(8'hA5, 1'b0, 1'b1);
      drain_reports();
      no_gaps = 1'b0;

      set_threshold(THR_BITS'(5));
      run_random_phase(260, 1'b1);
      set_threshold(THR_BITS'(1));
      run_random_phase(260, 1'b0);
      set_threshold(THR_BITS'(30));
      no_gaps = 1'b1;
      run_random_phase(260, 1'b0);
      no_gaps = 1'b0;
      set_threshold(THR_BITS'(0));
      run_random_phase(260, 1'b0);
      set_threshold(THR_BITS'($urandom_range(2, 20)));
      run_random_phase(260, 1'b0);

      repeat (8) @(posedge clock);
      if (board.pending() != 0) begin
         $error("%0d expected reports never arrived", board.pending());
         board.mismatches++;
      end
      $display("summary: %0d key samples, %0d reports checked, %0d long output stall(s)",
               board.samples_noted, board.reports_checked, hold_offs);
      $display("summary: thresholds 0 to 65535, taps, long presses, focus loss");
      if (board.mismatches == 0)
         $display("tb_key_tap_long_press_tracker_unit: PASS");
      else
         $display("tb_key_tap_long_press_tracker_unit: FAIL");
      $finish;
   end

endmodule
